FILE: hw/rtl/cplm_pkg.sv
`timescale 1ns / 1ps

package cplm_pkg;

  // Build-time limits and defaults.
  localparam int MAX_CHANNELS     = 6;
  localparam int CHANNELS_DEFAULT = 6;

  // Port widths.
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int IN_TDATA_W  = 136;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 64;

  // A reply always carries exactly eight payload bytes.
  localparam logic [6:0] REPLY_LENGTH = 7'd8;

  // Register indexes, one word apart on the configuration port.
  typedef enum logic [2:0] {
    REG_IDENTIFIER,
    REG_COMMAND,
    REG_DEVICE,
    REG_PERIOD,
    REG_TIMEOUT,
    REG_LIMIT,
    REG_STATE_LOW,
    REG_STATE_HIGH
  } reg_index_t;

  // Register reset values.
  localparam logic [28:0] RST_IDENTIFIER = 29'h1000_0001;
  localparam logic [7:0]  RST_COMMAND    = 8'h11;
  localparam logic [7:0]  RST_DEVICE     = 8'h01;
  localparam logic [15:0] RST_PERIOD     = 16'd200;
  localparam logic [15:0] RST_TIMEOUT    = 16'd150;
  localparam logic [7:0]  RST_LIMIT      = 8'd3;
  localparam logic [7:0]  RST_STATE_LOW  = 8'd0;
  localparam logic [7:0]  RST_STATE_HIGH = 8'd3;

  typedef struct packed {
    logic [28:0] monitor_identifier;
    logic [7:0]  command_byte;
    logic [7:0]  device_byte;
    logic [15:0] query_period_ms;
    logic [15:0] reply_timeout_ms;
    logic [7:0]  failure_limit;
    logic [7:0]  state_low;
    logic [7:0]  state_high;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        frame_present;
    logic [28:0] frame_identifier;
    logic        frame_extended;
    logic        frame_is_data;
    logic [6:0]  frame_length;
    logic [63:0] frame_payload;
    logic        transmit_ready;
  } item_t;

  typedef struct packed {
    logic        send_query;
    logic        is_online;
    logic [47:0] channel_states;
    logic        reply_pending;
    logic [7:0]  missed_count;
  } result_t;

endpackage

FILE: hw/rtl/cplm_regs.sv
`timescale 1ns / 1ps

module cplm_regs import cplm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_index_t reg_index;
  logic       wr_en;

  assign pready    = 1'b1;
  assign reg_index = reg_index_t'(paddr[ADDR_W-1:2]);
  assign wr_en     = psel && penable && pwrite && pready;

  // Register writes on the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.monitor_identifier <= RST_IDENTIFIER;
      cfg.command_byte       <= RST_COMMAND;
      cfg.device_byte        <= RST_DEVICE;
      cfg.query_period_ms    <= RST_PERIOD;
      cfg.reply_timeout_ms   <= RST_TIMEOUT;
      cfg.failure_limit      <= RST_LIMIT;
      cfg.state_low          <= RST_STATE_LOW;
      cfg.state_high         <= RST_STATE_HIGH;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_IDENTIFIER: cfg.monitor_identifier <= pwdata[28:0];
        REG_COMMAND:    cfg.command_byte       <= pwdata[7:0];
        REG_DEVICE:     cfg.device_byte        <= pwdata[7:0];
        REG_PERIOD:     cfg.query_period_ms    <= pwdata[15:0];
        REG_TIMEOUT:    cfg.reply_timeout_ms   <= pwdata[15:0];
        REG_LIMIT:      cfg.failure_limit      <= pwdata[7:0];
        REG_STATE_LOW:  cfg.state_low          <= pwdata[7:0];
        REG_STATE_HIGH: cfg.state_high         <= pwdata[7:0];
      endcase
    end
  end

  // Read-back, zero extended.
  always_comb begin
    unique case (reg_index)
      REG_IDENTIFIER: prdata = {3'd0, cfg.monitor_identifier};
      REG_COMMAND:    prdata = {24'd0, cfg.command_byte};
      REG_DEVICE:     prdata = {24'd0, cfg.device_byte};
      REG_PERIOD:     prdata = {16'd0, cfg.query_period_ms};
      REG_TIMEOUT:    prdata = {16'd0, cfg.reply_timeout_ms};
      REG_LIMIT:      prdata = {24'd0, cfg.failure_limit};
      REG_STATE_LOW:  prdata = {24'd0, cfg.state_low};
      REG_STATE_HIGH: prdata = {24'd0, cfg.state_high};
    endcase
  end

endmodule

FILE: hw/rtl/cplm_core.sv
`timescale 1ns / 1ps

module cplm_core import cplm_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    step_en,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic [7:0]  latched_state      [CHANNELS];
  logic [7:0]  latched_state_next [CHANNELS];
  logic        online_flag, online_flag_next;
  logic        awaiting_flag, awaiting_flag_next;
  logic [7:0]  failure_counter, failure_counter_next;
  logic        started_flag;
  logic [31:0] sent_time, sent_time_next;
  logic [31:0] attempt_time;

  logic        states_in_range;
  logic        reply_ok;
  logic        awaiting_after_reply;
  logic [7:0]  count_after_reply;
  logic        online_after_reply;
  logic [31:0] since_sent;
  logic [31:0] since_attempt;
  logic        timed_out;
  logic        awaiting_after_timeout;
  logic        query;

  // Every state byte of the reply has to lie inside the configured range.
  always_comb begin : range_check
    logic [7:0] state_byte;
    states_in_range = 1'b1;
    for (int k = 0; k < CHANNELS; k++) begin
      state_byte = item.frame_payload[8*(k+2) +: 8];
      if (state_byte < cfg.state_low || state_byte > cfg.state_high) begin
        states_in_range = 1'b0;
      end
    end
  end

  // Reply acceptance.
  assign reply_ok = item.frame_present && awaiting_flag && item.frame_extended &&
                    item.frame_is_data &&
                    (item.frame_identifier == cfg.monitor_identifier) &&
                    (item.frame_length == REPLY_LENGTH) &&
                    (item.frame_payload[7:0] == cfg.command_byte) &&
                    (item.frame_payload[15:8] == cfg.device_byte) &&
                    states_in_range;

  assign awaiting_after_reply = awaiting_flag && !reply_ok;
  assign count_after_reply    = reply_ok ? 8'd0 : failure_counter;
  assign online_after_reply   = reply_ok || online_flag;

  always_comb begin
    for (int k = 0; k < CHANNELS; k++) begin
      latched_state_next[k] = reply_ok ? item.frame_payload[8*(k+2) +: 8] : latched_state[k];
    end
  end

  // Timeout check; elapsed times wrap modulo 2^32.
  assign since_sent    = item.now_ms - sent_time;
  assign since_attempt = item.now_ms - attempt_time;
  assign timed_out     = awaiting_after_reply && (since_sent >= {16'd0, cfg.reply_timeout_ms});
  assign awaiting_after_timeout = awaiting_after_reply && !timed_out;

  always_comb begin
    failure_counter_next = count_after_reply;
    online_flag_next     = online_after_reply;
    if (timed_out) begin
      if (count_after_reply < cfg.failure_limit) begin
        failure_counter_next = count_after_reply + 8'd1;
      end
      if (failure_counter_next >= cfg.failure_limit) begin
        online_flag_next = 1'b0;
      end
    end
  end

  // Query issue; the wait only starts when the transmitter takes the frame.
  assign query = !awaiting_after_timeout &&
                 (!started_flag || (since_attempt >= {16'd0, cfg.query_period_ms}));

  always_comb begin
    awaiting_flag_next = awaiting_after_timeout;
    sent_time_next     = sent_time;
    if (query && item.transmit_ready) begin
      awaiting_flag_next = 1'b1;
      sent_time_next     = item.now_ms;
    end
  end

  // Monitor state, advanced once per item.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CHANNELS; k++) begin
        latched_state[k] <= 8'd0;
      end
      online_flag     <= 1'b0;
      awaiting_flag   <= 1'b0;
      failure_counter <= 8'd0;
      started_flag    <= 1'b0;
      sent_time       <= 32'd0;
      attempt_time    <= 32'd0;
    end else if (step_en) begin
      for (int k = 0; k < CHANNELS; k++) begin
        latched_state[k] <= latched_state_next[k];
      end
      online_flag     <= online_flag_next;
      awaiting_flag   <= awaiting_flag_next;
      failure_counter <= failure_counter_next;
      sent_time       <= sent_time_next;
      if (query) begin
        started_flag <= 1'b1;
        attempt_time <= item.now_ms;
      end
    end
  end

  // Result reflects the state after the step; unused channel bytes read as zero.
  always_comb begin
    res.send_query     = query;
    res.is_online      = online_flag_next;
    res.reply_pending  = awaiting_flag_next;
    res.missed_count   = failure_counter_next;
    res.channel_states = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      res.channel_states[8*k +: 8] = latched_state_next[k];
    end
  end

  // A wait can only exist after a query was attempted.
  assert property (@(posedge clk) disable iff (rst) awaiting_flag |-> started_flag)
    else $error("reply awaited without any query attempt");

  // A query records its time stamp.
  assert property (@(posedge clk) disable iff (rst)
    step_en && query |=> started_flag && (attempt_time == $past(item.now_ms)))
    else $error("query attempt time not recorded");

  // A valid reply clears the miss count and sets the board online.
  assert property (@(posedge clk) disable iff (rst)
    step_en && reply_ok |=> online_flag && (failure_counter == 8'd0))
    else $error("valid reply did not restore online state");

  // A timeout with the count at the limit leaves the board offline.
  assert property (@(posedge clk) disable iff (rst)
    step_en && timed_out && (failure_counter_next >= cfg.failure_limit) |=> !online_flag)
    else $error("online flag kept after reaching the miss limit");

endmodule

FILE: hw/rtl/can_poll_liveness_monitor_top.sv
`timescale 1ns / 1ps

// CAN poll liveness monitor. Each input beat is one service step: it checks a
// received frame against the expected reply, handles the reply timeout and
// decides whether a new query is due, then returns one result beat with the
// query strobe, the online flag, the latched channel states, the pending flag
// and the miss count. The block takes one beat per clock cycle unless the output
// side stalls. A beat is evaluated combinationally from the input register, and
// its result is then held in the output register until it is taken. While a
// result waits, the input register can still take one more beat; after that
// s_tready stays low until the waiting result leaves, so throughput only drops
// when the output side stalls. The user must write configuration over the
// register port only while no beat is in flight; the block does not enforce it.

module can_poll_liveness_monitor_top import cplm_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration port.
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready,
  // Step input: now_ms, frame_identifier, frame_length, frame_payload, transmit_ready.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // Step flags: frame_present, frame_extended, frame_is_data.
  input  logic [IN_TUSER_W-1:0]  s_tuser,
  // Result: send_query, is_online, channel_states, reply_pending, missed_count.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  cfg_t    cfg;
  item_t   item_in;
  item_t   item_reg;
  result_t res;
  result_t res_reg;
  logic    in_valid;
  logic    out_valid;
  logic    move;

  cplm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Unpack the input beat.
  always_comb begin
    item_in.now_ms           = s_tdata[31:0];
    item_in.frame_identifier = s_tdata[60:32];
    item_in.frame_length     = s_tdata[67:61];
    item_in.frame_payload    = s_tdata[131:68];
    item_in.transmit_ready   = s_tdata[132];
    item_in.frame_present    = s_tuser[0];
    item_in.frame_extended   = s_tuser[1];
    item_in.frame_is_data    = s_tuser[2];
  end

  // The step runs when the input register holds a beat and the output slot frees up.
  assign move     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (move) begin
        in_valid <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_reg <= item_in;
    end
    if (move) begin
      res_reg <= res;
    end
  end

  cplm_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (move),
    .item    (item_reg),
    .cfg     (cfg),
    .res     (res)
  );

  // Pack the result beat.
  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, res_reg.missed_count, res_reg.reply_pending,
                     res_reg.channel_states, res_reg.is_online, res_reg.send_query};

endmodule
